>>> rtl/core/qasu_pkg.sv
// Shared types, sizes and helpers for the quantum automaton state update block.
`timescale 1ns / 1ps
`default_nettype none
package qasu_pkg;

  localparam int MAX_STATES = 8;
  localparam int SYMBOLS    = 4;
  localparam int AMP_BITS   = 16;
  localparam int FRAC_BITS  = AMP_BITS - 2;

  localparam int IDX_W      = $clog2(MAX_STATES);
  localparam int SYM_W      = $clog2(SYMBOLS);
  localparam int SC_W       = 4;
  localparam int CMD_W      = 3;
  localparam int MAT_AW     = SYM_W + 2 * IDX_W;
  localparam int MAT_DEPTH  = SYMBOLS * MAX_STATES * MAX_STATES;
  localparam int PROD_W     = 2 * AMP_BITS;
  localparam int ACC_W      = PROD_W + IDX_W + 1;
  localparam int SH_W       = ACC_W - FRAC_BITS;

  localparam logic [SC_W-1:0] SC_RESET = SC_W'(3);

  typedef logic signed [AMP_BITS-1:0] amp_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    amp_t re;
    amp_t im;
  } cplx_t;

  localparam int CPLX_W = $bits(cplx_t);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_MAT  = 3'd0,
    CMD_WR_INIT = 3'd1,
    CMD_START   = 3'd2,
    CMD_APPLY   = 3'd3,
    CMD_FINISH  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_COMMIT,
    ST_EMIT
  } st_e;

  // Tag carried alongside each operand pair into the MAC unit
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] row;
  } mac_tag_t;

  // Floor shift by FRAC_BITS, then saturate to the amplitude range
  function automatic amp_t sat_rescale(acc_t acc);
    logic [SH_W-1:0] sh;
    logic            ovf;
    sh  = acc[ACC_W-1:FRAC_BITS];
    ovf = !((&sh[SH_W-1:AMP_BITS-1]) || !(|sh[SH_W-1:AMP_BITS-1]));
    if (ovf) begin
      sat_rescale = sh[SH_W-1] ? {1'b1, {(AMP_BITS-1){1'b0}}} : {1'b0, {(AMP_BITS-1){1'b1}}};
    end else begin
      sat_rescale = sh[AMP_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/qasu_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module qasu_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/qasu_cmac.sv
// Shared complex multiply-accumulate unit with rescale and saturation.
`timescale 1ns / 1ps
`default_nettype none
module qasu_cmac (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire qasu_pkg::mac_tag_t             tag_i,
  input  wire qasu_pkg::amp_t                 a_re_i,
  input  wire qasu_pkg::amp_t                 a_im_i,
  input  wire qasu_pkg::amp_t                 b_re_i,
  input  wire qasu_pkg::amp_t                 b_im_i,
  output logic                                res_valid_o,
  output logic [qasu_pkg::IDX_W-1:0]          res_row_o,
  output qasu_pkg::amp_t                      res_re_o,
  output qasu_pkg::amp_t                      res_im_o
);

  qasu_pkg::mac_tag_t m_tag_q;
  qasu_pkg::prod_t    rr_q, ii_q, ri_q, ir_q;
  qasu_pkg::acc_t     acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [qasu_pkg::PROD_W:0] sum_re, sum_im;
  logic                             done_q;
  logic [qasu_pkg::IDX_W-1:0]       row_q;

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tag_q <= '0;
    end else begin
      m_tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q <= a_re_i * b_re_i;
    ii_q <= a_im_i * b_im_i;
    ri_q <= a_re_i * b_im_i;
    ir_q <= a_im_i * b_re_i;
  end

  // accumulate stage
  always_comb begin
    sum_re   = $signed({rr_q[qasu_pkg::PROD_W-1], rr_q}) - $signed({ii_q[qasu_pkg::PROD_W-1], ii_q});
    sum_im   = $signed({ri_q[qasu_pkg::PROD_W-1], ri_q}) + $signed({ir_q[qasu_pkg::PROD_W-1], ir_q});
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (m_tag_q.vld) begin
      if (m_tag_q.first) begin
        acc_re_d = qasu_pkg::acc_t'(sum_re);
        acc_im_d = qasu_pkg::acc_t'(sum_im);
      end else begin
        acc_re_d = acc_re_q + qasu_pkg::acc_t'(sum_re);
        acc_im_d = acc_im_q + qasu_pkg::acc_t'(sum_im);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= m_tag_q.vld & m_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    row_q    <= m_tag_q.row;
  end

  assign res_valid_o = done_q;
  assign res_row_o   = row_q;
  assign res_re_o    = qasu_pkg::sat_rescale(acc_re_q);
  assign res_im_o    = qasu_pkg::sat_rescale(acc_im_q);

endmodule
`default_nettype wire

>>> rtl/core/quantum_automaton_state_update.sv
// Top level: command decode, matrix store, vectors and the apply/finish sequencer.
// Load, start and ignored commands complete as they are accepted; apply runs n*n terms
// (n = states in use, up to 8) through the one shared complex MAC issuing a term per cycle.
// Finish emits n results, one per cycle while the output side takes them.
// One item at a time: the input is ready only when the previous item is fully done.
// Reset (async, active low) zeroes the vectors, sets state_count to 3 and clears the
// per-entry matrix valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module quantum_automaton_state_update (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [qasu_pkg::SC_W-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [qasu_pkg::CMD_W-1:0]     command_i,
  input  wire logic [qasu_pkg::SYM_W-1:0]     symbol_i,
  input  wire logic [qasu_pkg::IDX_W-1:0]     row_i,
  input  wire logic [qasu_pkg::IDX_W-1:0]     column_i,
  input  wire qasu_pkg::amp_t                 value_real_i,
  input  wire qasu_pkg::amp_t                 value_imag_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [qasu_pkg::IDX_W-1:0]          amp_index_o,
  output qasu_pkg::amp_t                      amp_real_o,
  output qasu_pkg::amp_t                      amp_imag_o,
  output logic                                last_o
);

  qasu_pkg::st_e state_q, state_d;
  qasu_pkg::cmd_e cmd;

  logic [qasu_pkg::SC_W-1:0]   sc_q;
  logic [qasu_pkg::IDX_W-1:0]  nm1;
  logic [qasu_pkg::IDX_W-1:0]  i_q, j_q, e_q;
  logic [qasu_pkg::SYM_W-1:0]  sym_q;
  logic                        in_acc, out_acc;
  logic                        issue, commit;
  logic                        mac_end;

  qasu_pkg::cplx_t init_q [qasu_pkg::MAX_STATES];
  qasu_pkg::cplx_t work_q [qasu_pkg::MAX_STATES];
  qasu_pkg::cplx_t nxt_q  [qasu_pkg::MAX_STATES];
  qasu_pkg::cplx_t wj_q;
  qasu_pkg::cplx_t wdata;
  qasu_pkg::cplx_t rdata;
  qasu_pkg::cplx_t mat_op;

  logic [qasu_pkg::MAT_DEPTH-1:0] vld_q;
  logic                           mvld_q;
  logic                           ram_we;
  logic [qasu_pkg::MAT_AW-1:0]    ram_addr;
  logic [qasu_pkg::MAT_AW-1:0]    wr_addr;
  logic [qasu_pkg::CPLX_W-1:0]    ram_rdata;

  qasu_pkg::mac_tag_t          tag_q;
  logic                        res_valid;
  logic [qasu_pkg::IDX_W-1:0]  res_row;
  qasu_pkg::amp_t              res_re, res_im;

  assign cmd     = qasu_pkg::cmd_e'(command_i);
  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;
  assign mac_end = (i_q == nm1) && (j_q == nm1);

  // states in use, minus one
  always_comb begin
    if (sc_q == '0) begin
      nm1 = '0;
    end else if (sc_q > qasu_pkg::MAX_STATES) begin
      nm1 = qasu_pkg::IDX_W'(qasu_pkg::MAX_STATES - 1);
    end else begin
      nm1 = qasu_pkg::IDX_W'(sc_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= qasu_pkg::SC_RESET;
    end else if (cfg_we_i) begin
      sc_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qasu_pkg::ST_IDLE: begin
        if (in_acc && cmd == qasu_pkg::CMD_APPLY) begin
          state_d = qasu_pkg::ST_MAC;
        end else if (in_acc && cmd == qasu_pkg::CMD_FINISH) begin
          state_d = qasu_pkg::ST_EMIT;
        end
      end
      qasu_pkg::ST_MAC: begin
        if (mac_end) begin
          state_d = qasu_pkg::ST_DRAIN;
        end
      end
      qasu_pkg::ST_DRAIN: begin
        if (res_valid && res_row == nm1) begin
          state_d = qasu_pkg::ST_COMMIT;
        end
      end
      qasu_pkg::ST_COMMIT: state_d = qasu_pkg::ST_IDLE;
      qasu_pkg::ST_EMIT: begin
        if (out_ready_i && e_q == nm1) begin
          state_d = qasu_pkg::ST_IDLE;
        end
      end
      default: state_d = qasu_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    issue       = 1'b0;
    commit      = 1'b0;
    unique case (state_q)
      qasu_pkg::ST_IDLE:   in_ready_o  = 1'b1;
      qasu_pkg::ST_MAC:    issue       = 1'b1;
      qasu_pkg::ST_DRAIN:  ;
      qasu_pkg::ST_COMMIT: commit      = 1'b1;
      qasu_pkg::ST_EMIT:   out_valid_o = 1'b1;
      default:             ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qasu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q   <= '0;
      j_q   <= '0;
      e_q   <= '0;
      sym_q <= '0;
    end else begin
      if (in_acc) begin
        i_q   <= '0;
        j_q   <= '0;
        e_q   <= '0;
        sym_q <= symbol_i;
      end else if (issue) begin
        if (j_q == nm1) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (out_acc) begin
        e_q <= e_q + 1'b1;
      end
    end
  end

  // matrix store
  assign wr_addr  = {symbol_i, row_i, column_i};
  assign ram_we   = in_acc && cmd == qasu_pkg::CMD_WR_MAT;
  assign ram_addr = ram_we ? wr_addr : {sym_q, i_q, j_q};
  assign wdata    = '{re: value_real_i, im: value_imag_i};

  qasu_ram #(
    .Width (qasu_pkg::CPLX_W),
    .Depth (qasu_pkg::MAT_DEPTH)
  ) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      mvld_q <= 1'b0;
      tag_q  <= '0;
    end else begin
      if (ram_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      mvld_q    <= vld_q[ram_addr];
      tag_q.vld   <= issue;
      tag_q.first <= (j_q == '0);
      tag_q.last  <= (j_q == nm1);
      tag_q.row   <= i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wj_q <= work_q[j_q];
  end

  assign rdata  = qasu_pkg::cplx_t'(ram_rdata);
  assign mat_op = mvld_q ? rdata : '0;

  qasu_cmac u_cmac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_q),
    .a_re_i      (mat_op.re),
    .a_im_i      (mat_op.im),
    .b_re_i      (wj_q.re),
    .b_im_i      (wj_q.im),
    .res_valid_o (res_valid),
    .res_row_o   (res_row),
    .res_re_o    (res_re),
    .res_im_o    (res_im)
  );

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      nxt_q[res_row] <= '{re: res_re, im: res_im};
    end
  end

  // vectors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < qasu_pkg::MAX_STATES; k++) begin
        init_q[k] <= '0;
        work_q[k] <= '0;
      end
    end else begin
      if (in_acc && cmd == qasu_pkg::CMD_WR_INIT) begin
        init_q[row_i] <= wdata;
      end
      if (in_acc && cmd == qasu_pkg::CMD_START) begin
        for (int k = 0; k < qasu_pkg::MAX_STATES; k++) begin
          work_q[k] <= init_q[k];
        end
      end
      if (commit) begin
        for (int k = 0; k < qasu_pkg::MAX_STATES; k++) begin
          work_q[k] <= (qasu_pkg::IDX_W'(k) <= nm1) ? nxt_q[k] : '0;
        end
      end
    end
  end

  // result channel
  assign amp_index_o = e_q;
  assign amp_real_o  = work_q[e_q].re;
  assign amp_imag_o  = work_q[e_q].im;
  assign last_o      = (e_q == nm1);

  // checks
  a_out_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result shown while input ready");

  a_res_in_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (state_q == qasu_pkg::ST_MAC || state_q == qasu_pkg::ST_DRAIN))
    else $error("MAC result outside apply");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (i_q <= nm1 && j_q <= nm1))
    else $error("MAC index past states in use");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd == qasu_pkg::CMD_FINISH) |=> (out_valid_o && e_q == '0))
    else $error("finish did not start burst at index zero");

  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_o) |=> (out_valid_o && e_q == $past(e_q) + 1'b1))
    else $error("burst index skipped");

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for quantum_automaton_state_update with an amplitude scoreboard.
`timescale 1ns / 1ps
module tb;
  import qasu_pkg::*;

  localparam int ITEMS          = 280;
  localparam int DIRECTED_ITEMS = 22;
  localparam int APPLY_SETTLE   = 80;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_SETTINGS   = 8;

  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    amp_t             re;
    amp_t             im;
    logic             is_last;
  } amp_rec_t;

  class qfa_scoreboard;
    cplx_t           trans_mat [SYMBOLS][MAX_STATES][MAX_STATES];
    cplx_t           init_vec  [MAX_STATES];
    cplx_t           work_vec  [MAX_STATES];
    logic [SC_W-1:0] count_reg;
    amp_rec_t        expected_amps[$];
    int              errors;
    int              checked;
    int              applies;
    int              finishes;

    function new();
      for (int s = 0; s < SYMBOLS; s++)
        for (int r = 0; r < MAX_STATES; r++)
          for (int c = 0; c < MAX_STATES; c++)
            trans_mat[s][r][c] = '0;
      for (int i = 0; i < MAX_STATES; i++) begin
        init_vec[i] = '0;
        work_vec[i] = '0;
      end
      count_reg = SC_RESET;
      errors    = 0;
      checked   = 0;
      applies   = 0;
      finishes  = 0;
    endfunction

    function void report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_count(logic [SC_W-1:0] val);
      count_reg = val;
    endfunction

    function int states_used();
      int n;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > MAX_STATES) n = MAX_STATES;
      return n;
    endfunction

    function int pending();
      return expected_amps.size();
    endfunction

    function amp_t floor_sat(longint acc);
      longint q;
      q = acc >>> FRAC_BITS;
      if (q > 32767) return amp_t'(32767);
      if (q < -32768) return amp_t'(-32768);
      return amp_t'(q);
    endfunction

    function void apply_symbol(logic [SYM_W-1:0] sym);
      cplx_t  nv [MAX_STATES];
      longint ar;
      longint ai;
      amp_t   a, b, c, d;
      int     n;
      n = states_used();
      for (int i = 0; i < MAX_STATES; i++) nv[i] = '0;
      for (int i = 0; i < n; i++) begin
        ar = 0;
        ai = 0;
        for (int j = 0; j < n; j++) begin
          a = trans_mat[sym][i][j].re;
          b = trans_mat[sym][i][j].im;
          c = work_vec[j].re;
          d = work_vec[j].im;
          ar += longint'(a) * longint'(c) - longint'(b) * longint'(d);
          ai += longint'(a) * longint'(d) + longint'(b) * longint'(c);
        end
        nv[i].re = floor_sat(ar);
        nv[i].im = floor_sat(ai);
      end
      for (int i = 0; i < MAX_STATES; i++) work_vec[i] = nv[i];
    endfunction

    function void take_command(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                               logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               amp_t vr, amp_t vi);
      amp_rec_t rec;
      int       n;
      n = states_used();
      case (cmd)
        CMD_WR_MAT: begin
          trans_mat[sym][row][col] = '{re: vr, im: vi};
        end
        CMD_WR_INIT: begin
          init_vec[row] = '{re: vr, im: vi};
        end
        CMD_START: begin
          for (int i = 0; i < MAX_STATES; i++) work_vec[i] = init_vec[i];
        end
        CMD_APPLY: begin
          apply_symbol(sym);
          applies++;
        end
        CMD_FINISH: begin
          finishes++;
          for (int i = 0; i < n; i++) begin
            rec.index   = IDX_W'(i);
            rec.re      = work_vec[i].re;
            rec.im      = work_vec[i].im;
            rec.is_last = (i == n - 1);
            expected_amps.push_back(rec);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_amplitude(logic [IDX_W-1:0] idx, amp_t re, amp_t im, logic lst);
      amp_rec_t want;
      if (expected_amps.size() == 0) begin
        report($sformatf("unexpected amplitude transfer, index %0d", idx));
        return;
      end
      want = expected_amps.pop_front();
      checked++;
      if (idx !== want.index)
        report($sformatf("amp_index got %0d expected %0d", idx, want.index));
      if (re !== want.re)
        report($sformatf("amp %0d real got %0d expected %0d", want.index, re, want.re));
      if (im !== want.im)
        report($sformatf("amp %0d imag got %0d expected %0d", want.index, im, want.im));
      if (lst !== want.is_last)
        report($sformatf("amp %0d last got %0b expected %0b", want.index, lst, want.is_last));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [SC_W-1:0]  cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CMD_W-1:0] command_i;
  logic [SYM_W-1:0] symbol_i;
  logic [IDX_W-1:0] row_i;
  logic [IDX_W-1:0] column_i;
  amp_t             value_real_i;
  amp_t             value_imag_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [IDX_W-1:0] amp_index_o;
  amp_t             amp_real_o;
  amp_t             amp_imag_o;
  logic             last_o;

  qfa_scoreboard sb;
  int            sent_items;
  int            cfg_writes;
  int            burst_left;
  bit            gaps_on;
  int            hold_requests;
  int            hold_seen;
  int            hold_left;
  int            pat_age;
  logic [15:0]   ready_pat;
  int            idle_cycles;

  logic [SC_W-1:0] settings [NUM_SETTINGS] = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd5, 4'd2, 4'd12, 4'd7};

  quantum_automaton_state_update DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .symbol_i     (symbol_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .value_real_i (value_real_i),
    .value_imag_i (value_imag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .amp_index_o  (amp_index_o),
    .amp_real_o   (amp_real_o),
    .amp_imag_o   (amp_imag_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic amp_t rand_amp();
    case ($urandom_range(0, 3))
      0:       return amp_t'($urandom);
      1, 2:    return amp_t'(int'($urandom_range(0, 16384)) - 8192);
      default: begin
        case ($urandom_range(0, 3))
          0:       return amp_t'(32767);
          1:       return amp_t'(-32768);
          2:       return amp_t'(16384);
          default: return amp_t'(0);
        endcase
      end
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int n);
    if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, MAX_STATES - 1));
    return IDX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                          input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                          input amp_t vr, input amp_t vi);
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    symbol_i     <= sym;
    row_i        <= row;
    column_i     <= col;
    value_real_i <= vr;
    value_imag_i <= vi;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_command(cmd, sym, row, col, vr, vi);
    sent_items++;
    if (!gaps_on || burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_noise();
    send_cmd(CMD_W'($urandom_range(0, 7)), SYM_W'($urandom), IDX_W'($urandom),
             IDX_W'($urandom), amp_t'($urandom), amp_t'($urandom));
  endtask

  task automatic run_string();
    int               n;
    int               shift;
    logic [SYM_W-1:0] sym;
    n   = sb.states_used();
    sym = SYM_W'($urandom_range(0, SYMBOLS - 1));
    if ($urandom_range(0, 2) == 0) begin
      shift = $urandom_range(0, n - 1);
      for (int r = 0; r < n; r++)
        send_cmd(CMD_WR_MAT, sym, IDX_W'(r), IDX_W'((r + shift) % n), rand_amp(), rand_amp());
    end else begin
      repeat ($urandom_range(1, 5))
        send_cmd(CMD_WR_MAT, sym, pick_index(n), pick_index(n), rand_amp(), rand_amp());
    end
    if ($urandom_range(0, 2) == 0) begin
      for (int r = 0; r < n; r++)
        send_cmd(CMD_WR_INIT, SYM_W'($urandom), IDX_W'(r), IDX_W'($urandom),
                 rand_amp(), rand_amp());
    end else begin
      repeat ($urandom_range(0, 3))
        send_cmd(CMD_WR_INIT, SYM_W'($urandom), pick_index(n), IDX_W'($urandom),
                 rand_amp(), rand_amp());
    end
    if ($urandom_range(0, 5) != 0)
      send_cmd(CMD_START, SYM_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
               amp_t'($urandom), amp_t'($urandom));
    repeat ($urandom_range(1, 3))
      send_cmd(CMD_APPLY, ($urandom_range(0, 2) == 0) ? SYM_W'($urandom) : sym,
               IDX_W'($urandom), IDX_W'($urandom), amp_t'($urandom), amp_t'($urandom));
    send_cmd(CMD_FINISH, SYM_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
             amp_t'($urandom), amp_t'($urandom));
  endtask

  // Quiesce, let any apply in flight finish, then write the state count
  task automatic drain_and_config(input logic [SC_W-1:0] val);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (APPLY_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(val);
    cfg_writes++;
    burst_left = $urandom_range(0, 12);
  endtask

  task automatic run_directed();
    send_cmd(CMD_FINISH, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_APPLY, 2'd2, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_FINISH, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_WR_MAT, 2'd0, 3'd0, 3'd0, amp_t'(32767), amp_t'(-32768));
    send_cmd(CMD_WR_MAT, 2'd0, 3'd0, 3'd1, amp_t'(-32768), amp_t'(-32768));
    send_cmd(CMD_WR_MAT, 2'd0, 3'd1, 3'd1, amp_t'(16384), amp_t'(0));
    send_cmd(CMD_WR_MAT, 2'd0, 3'd2, 3'd2, amp_t'(0), amp_t'(16384));
    send_cmd(CMD_WR_MAT, 2'd0, 3'd2, 3'd0, amp_t'(-1), amp_t'(1));
    send_cmd(CMD_WR_MAT, 2'd0, 3'd7, 3'd7, amp_t'(12345), amp_t'(-12345));
    send_cmd(CMD_WR_INIT, 2'd3, 3'd0, 3'd7, amp_t'(32767), amp_t'(-32768));
    send_cmd(CMD_WR_INIT, 2'd0, 3'd1, 3'd0, amp_t'(-32768), amp_t'(32767));
    send_cmd(CMD_WR_INIT, 2'd0, 3'd2, 3'd0, amp_t'(1), amp_t'(-3));
    send_cmd(CMD_WR_INIT, 2'd0, 3'd7, 3'd0, amp_t'(-16384), amp_t'(16384));
    send_cmd(CMD_START, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_APPLY, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_FINISH, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_RSVD_FIRST, 2'd3, 3'd7, 3'd7, amp_t'(-1), amp_t'(-1));
    send_cmd(CMD_RSVD_LAST, 2'd3, 3'd7, 3'd7, amp_t'(-1), amp_t'(-1));
    send_cmd(CMD_START, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_FINISH, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_APPLY, 2'd3, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
    send_cmd(CMD_FINISH, 2'd0, 3'd0, 3'd0, amp_t'(0), amp_t'(0));
  endtask

  // Receiver: rotating ready pattern, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age   = $urandom_range(16, 96);
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
      pat_age--;
      out_ready_i <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_amplitude(amp_index_o, amp_real_o, amp_imag_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb            = new();
    sent_items    = 0;
    cfg_writes    = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_requests = 0;
    hold_seen     = 0;
    hold_left     = 0;
    pat_age       = 0;
    ready_pat     = '1;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = '0;
    symbol_i      = '0;
    row_i         = '0;
    column_i      = '0;
    value_real_i  = '0;
    value_imag_i  = '0;
    out_ready_i   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int p = 0; p <= NUM_SETTINGS; p++) begin
      if (p > 0) drain_and_config(settings[p-1]);
      gaps_on = (p % 3) != 2;
      if (p == 2) begin
        // full-size finishes against a stalled output
        gaps_on = 1'b0;
        hold_requests++;
        repeat (3) run_string();
        gaps_on = 1'b1;
      end
      while (sent_items < DIRECTED_ITEMS + (p + 1) * (ITEMS - DIRECTED_ITEMS) / (NUM_SETTINGS + 1))
        if ($urandom_range(0, 9) == 0) send_noise();
        else run_string();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (APPLY_SETTLE) @(posedge clk_i);
    $display("Covered %0d input transfers (%0d applies, %0d finishes), %0d amplitude checks",
             sent_items, sb.applies, sb.finishes, sb.checked);
    $display("State count written %0d times, incl. 0, 1, 8 and above-range values", cfg_writes);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
